/* rtl/set_assoc_lru_cache_tag_sim_core_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef SET_ASSOC_LRU_CACHE_TAG_SIM_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAG_SIM_CORE_MACROS_SVH

// Condition implies consequence in the same cycle.
`define SALC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define SALC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/salc_pkg.sv */
package salc_pkg;

   localparam int MAX_SET_BITS = 6;
   localparam int MAX_WAYS     = 8;
   localparam int ADDR_BITS    = 64;

   localparam int NUM_SETS      = 1 << MAX_SET_BITS;
   localparam int SET_IDX_BITS  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_IDX_BITS  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_LEAVES    = 1 << WAY_IDX_BITS;
   localparam int WAY_CNT_BITS  = $clog2(MAX_WAYS + 1);
   localparam int TAG_BITS      = ADDR_BITS;
   localparam int TIME_BITS     = 64;
   localparam int COUNT_BITS    = 32;

   localparam int CFG_SET_W     = 3;
   localparam int CFG_WAYS_W    = 4;
   localparam int CFG_OFF_W     = 6;
   localparam int SHIFT_W       = CFG_OFF_W + 1;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd2;

   // access kinds
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // outcomes
   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_MISS  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   typedef struct packed {
      logic                 valid;
      logic [TAG_BITS-1:0]  tag;
      logic [TIME_BITS-1:0] last_use;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   typedef struct packed {
      logic en;
      logic [TIME_BITS-1:0] val;
      logic [WAY_IDX_BITS-1:0] idx;
   } node_type;

   typedef struct packed {
      logic start;   // latch address, read set row
      logic cmp;     // tag compare, first tree level
      logic commit;  // write row back, post first result
      logic second;  // post the store half of a modify
      logic last;    // last flag for the committed result
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

/* rtl/set_assoc_lru_cache_tag_sim_core.sv */
// Set-associative cache tag store with least-recently-used replacement.
// Request channel (req_): op (load, store, modify) and a byte address. Each
// request is split into set index and tag by the offset and set bit counts.
// Response channel (rsp_): one result per load or store, two per modify (the
// load outcome, then a store outcome that always hits); rsp_last marks the
// final one. Every result carries running hit, miss and eviction totals.
// Register port (csr_): index 0 set bits, 1 ways, 2 offset bits; always ready,
// write only while no request is in flight.
// Steps: a request runs through accept and row read, tag compare with the
// first level of the age tree, then way choice and row write-back; one set row
// of the tag memory is read and written per request. The next request is taken
// once the last has posted its results; a modify holds the request channel
// until its second result is posted. An unused op code is taken and dropped.
// Reset clears the registers to defaults, the totals, the access clock and a
// per-set row-valid flag, so no memory clearing pass is needed.
// A stalled response holds in the output register; the next request is still
// taken and runs up to its write-back, then waits for the register to free.
module set_assoc_lru_cache_tag_sim_core import salc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_op,
   input  logic [ADDR_BITS-1:0]   req_address,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_outcome,
   output logic                   rsp_last,
   output logic [COUNT_BITS-1:0]  rsp_hit_total,
   output logic [COUNT_BITS-1:0]  rsp_miss_total,
   output logic [COUNT_BITS-1:0]  rsp_eviction_total,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   salc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_address        (req_address),
      .csr_we             (csr_valid & csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_outcome        (rsp_outcome),
      .rsp_last           (rsp_last),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total)
   );

endmodule

/* rtl/salc_ctrl.sv */
module salc_ctrl import salc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_op,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CMP    = 2'd1;
   localparam logic [1:0] ST_PICK   = 2'd2;
   localparam logic [1:0] ST_SECOND = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       modify_ff, modify_in;

   always_comb begin
      state_in  = state_ff;
      modify_in = modify_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            // an unused op code is taken and dropped
            if (req_valid && req_op != OP_NONE) begin
               cmd.start = 1'b1;
               modify_in = (req_op == OP_MODIFY);
               state_in  = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               cmd.last   = !modify_ff;
               state_in   = modify_ff ? ST_SECOND : ST_IDLE;
            end
         end
         ST_SECOND: begin
            if (status.out_free) begin
               cmd.second = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         modify_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         modify_ff <= modify_in;
      end
   end

endmodule

/* rtl/salc_dp.sv */
module salc_dp import salc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic [ADDR_BITS-1:0]   req_address,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_outcome,
   output logic                   rsp_last,
   output logic [COUNT_BITS-1:0]  rsp_hit_total,
   output logic [COUNT_BITS-1:0]  rsp_miss_total,
   output logic [COUNT_BITS-1:0]  rsp_eviction_total
);

   // configuration
   logic [CFG_SET_W-1:0]  set_bits_ff;
   logic [CFG_WAYS_W-1:0] ways_ff;
   logic [CFG_OFF_W-1:0]  offset_bits_ff;

   // tag memory, one row per set; rows never written read as all zero
   row_type               mem_row [NUM_SETS];
   logic [NUM_SETS-1:0]   row_vld_ff;
   row_type               rd_row_ff;
   logic                  rd_vld_ff;

   logic [SET_IDX_BITS-1:0] set_ff;
   logic [TAG_BITS-1:0]     tag_ff;
   logic [WAY_CNT_BITS-1:0] nw_ff;

   logic [MAX_WAYS-1:0]   hit_ff, inv_ff;
   node_type              l1_ff [WAY_LEAVES/2];

   logic [TIME_BITS-1:0]  time_ff;
   logic [COUNT_BITS-1:0] hits_ff, misses_ff, evicts_ff;

   logic                  out_valid_ff;
   logic [1:0]            out_outcome_ff;
   logic                  out_last_ff;
   logic [COUNT_BITS-1:0] out_hits_ff, out_misses_ff, out_evicts_ff;

   // address split
   logic [CFG_SET_W-1:0]    sb;
   logic [SHIFT_W-1:0]      tag_shift;
   logic [ADDR_BITS-1:0]    addr_sh;
   logic [SET_IDX_BITS-1:0] set_mask, set_idx;
   logic [TAG_BITS-1:0]     tag_val;
   logic [WAY_CNT_BITS-1:0] nw;

   always_comb begin
      sb = (int'(set_bits_ff) > MAX_SET_BITS) ? CFG_SET_W'(MAX_SET_BITS) : set_bits_ff;
      for (int i = 0; i < SET_IDX_BITS; i++) begin
         set_mask[i] = (i < int'(sb));
      end
      addr_sh   = (SHIFT_W'(offset_bits_ff) >= SHIFT_W'(ADDR_BITS)) ? '0
                  : req_address >> offset_bits_ff;
      set_idx   = SET_IDX_BITS'(addr_sh) & set_mask;
      tag_shift = SHIFT_W'(offset_bits_ff) + SHIFT_W'(sb);
      tag_val   = (tag_shift >= SHIFT_W'(ADDR_BITS)) ? '0
                  : TAG_BITS'(req_address >> tag_shift);
      if (ways_ff == '0) begin
         nw = WAY_CNT_BITS'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         nw = WAY_CNT_BITS'(MAX_WAYS);
      end else begin
         nw = WAY_CNT_BITS'(ways_ff);
      end
   end

   function automatic node_type node_min(node_type a, node_type b);
      if (a.en && (!b.en || a.val <= b.val)) begin
         return a;
      end
      return b;
   endfunction

   // compare stage
   row_type             row_cur;
   logic [MAX_WAYS-1:0] hit_vec, inv_vec;
   node_type            leaf [WAY_LEAVES];

   always_comb begin
      row_cur = rd_vld_ff ? rd_row_ff : '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         hit_vec[w] = (w < int'(nw_ff)) && row_cur[w].valid && (row_cur[w].tag == tag_ff);
         inv_vec[w] = (w < int'(nw_ff)) && !row_cur[w].valid;
      end
      for (int w = 0; w < WAY_LEAVES; w++) begin
         leaf[w].en  = (w < MAX_WAYS) && (w < int'(nw_ff));
         leaf[w].val = (w < MAX_WAYS) ? row_cur[w].last_use : '0;
         leaf[w].idx = WAY_IDX_BITS'(w);
      end
   end

   // pick stage: rest of the age tree, way choice, new row
   node_type                nodes [WAY_LEAVES/2];
   logic [WAY_IDX_BITS-1:0] hit_way, inv_way, way_sel;
   logic [1:0]              outcome;
   row_type                 new_row;
   logic [COUNT_BITS-1:0]   hits_nx, misses_nx, evicts_nx;

   always_comb begin
      nodes = l1_ff;
      for (int s = WAY_LEAVES / 4; s >= 1; s = s >> 1) begin
         for (int i = 0; i < s; i++) begin
            nodes[i] = node_min(nodes[2*i], nodes[2*i+1]);
         end
      end
      hit_way = '0;
      inv_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_ff[w]) hit_way = WAY_IDX_BITS'(w);
         if (inv_ff[w]) inv_way = WAY_IDX_BITS'(w);
      end
      if (|hit_ff) begin
         outcome = OUT_HIT;
         way_sel = hit_way;
      end else if (|inv_ff) begin
         outcome = OUT_MISS;
         way_sel = inv_way;
      end else begin
         outcome = OUT_EVICT;
         way_sel = nodes[0].idx;
      end
      new_row                   = row_cur;
      new_row[way_sel].valid    = 1'b1;
      new_row[way_sel].tag      = tag_ff;
      new_row[way_sel].last_use = time_ff;
      hits_nx   = hits_ff;
      misses_nx = misses_ff;
      evicts_nx = evicts_ff;
      if (cmd.second || outcome == OUT_HIT) begin
         hits_nx = hits_ff + COUNT_BITS'(1);
      end else begin
         misses_nx = misses_ff + COUNT_BITS'(1);
         if (outcome == OUT_EVICT) evicts_nx = evicts_ff + COUNT_BITS'(1);
      end
   end

   // memory
   always_ff @(posedge clock) begin
      if (cmd.commit) mem_row[set_ff] <= new_row;
      if (cmd.start) begin
         rd_row_ff <= mem_row[set_idx];
         rd_vld_ff <= row_vld_ff[set_idx];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         set_ff <= set_idx;
         tag_ff <= tag_val;
         nw_ff  <= nw;
      end
      if (cmd.cmp) begin
         hit_ff <= hit_vec;
         inv_ff <= inv_vec;
         for (int i = 0; i < WAY_LEAVES / 2; i++) begin
            l1_ff[i] <= node_min(leaf[2*i], leaf[2*i+1]);
         end
      end
      if (cmd.commit || cmd.second) begin
         out_outcome_ff <= cmd.second ? OUT_HIT : outcome;
         out_last_ff    <= cmd.second ? 1'b1 : cmd.last;
         out_hits_ff    <= hits_nx;
         out_misses_ff  <= misses_nx;
         out_evicts_ff  <= evicts_nx;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= '0;
         ways_ff        <= CFG_WAYS_W'(1);
         offset_bits_ff <= '0;
         row_vld_ff     <= '0;
         time_ff        <= '0;
         hits_ff        <= '0;
         misses_ff      <= '0;
         evicts_ff      <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SET_BITS:    set_bits_ff    <= CFG_SET_W'(csr_data);
               CSR_WAYS:        ways_ff        <= CFG_WAYS_W'(csr_data);
               CSR_OFFSET_BITS: offset_bits_ff <= CFG_OFF_W'(csr_data);
               default: ;
            endcase
         end
         if (cmd.commit) begin
            row_vld_ff[set_ff] <= 1'b1;
            time_ff            <= time_ff + TIME_BITS'(1);
         end
         if (cmd.commit || cmd.second) begin
            hits_ff      <= hits_nx;
            misses_ff    <= misses_nx;
            evicts_ff    <= evicts_nx;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free    = !out_valid_ff || rsp_ready;
   assign rsp_valid          = out_valid_ff;
   assign rsp_outcome        = out_outcome_ff;
   assign rsp_last           = out_last_ff;
   assign rsp_hit_total      = out_hits_ff;
   assign rsp_miss_total     = out_misses_ff;
   assign rsp_eviction_total = out_evicts_ff;

endmodule

/* rtl/salc_checker.sv */
`include "set_assoc_lru_cache_tag_sim_core_macros.svh"

module salc_checker import salc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_outcome,
   input logic                  rsp_last,
   input logic [COUNT_BITS-1:0] rsp_hit_total,
   input logic [COUNT_BITS-1:0] rsp_miss_total,
   input logic [COUNT_BITS-1:0] rsp_eviction_total
);

   // a stalled response keeps its payload
   `SALC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_outcome) && $stable(rsp_last) && $stable(rsp_hit_total) && $stable(rsp_miss_total) && $stable(rsp_eviction_total), "response changed while stalled")

   // reset empties the output register
   `SALC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

   // the store half of a modify follows at once as a hit
   `SALC_ASSERT_NEXT(a_modify_second, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid && rsp_last && rsp_outcome == OUT_HIT && rsp_hit_total == $past(rsp_hit_total) + 32'd1, "modify store half missing or wrong")

   // no new request while a modify still owes its second result
   `SALC_ASSERT_NOW(a_modify_blocks, clock, reset, rsp_valid && !rsp_last, !req_ready, "request taken mid modify")

endmodule

bind set_assoc_lru_cache_tag_sim_core salc_checker u_salc_checker (.*);
